// ===== design/cti_pkg.sv =====
// shared constants, codes and record types for the connection table
package cti_pkg;

   localparam int SLOTS     = 64;
   localparam int TIME_BITS = 32;
   localparam int ADDR_BITS = $clog2(SLOTS);
   localparam int CNT_BITS  = $clog2(SLOTS + 1);
   localparam int ID_BITS   = 6;
   localparam int CMP_BITS  = (ID_BITS > CNT_BITS) ? ID_BITS : CNT_BITS;
   localparam int TOUT_BITS = 32;

   localparam logic [TOUT_BITS-1:0] TIMEOUT_RESET = TOUT_BITS'(1000);

   localparam logic [2:0] OP_OPEN   = 3'd0;
   localparam logic [2:0] OP_CLOSE  = 3'd1;
   localparam logic [2:0] OP_TOUCH  = 3'd2;
   localparam logic [2:0] OP_QUAR   = 3'd3;
   localparam logic [2:0] OP_EXPIRE = 3'd4;
   localparam logic [2:0] OP_FIND   = 3'd5;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_NOID  = 3'd1;
   localparam logic [2:0] ST_WRONG = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;
   localparam logic [2:0] ST_NONE  = 3'd5;

   localparam logic [1:0] CS_CONN = 2'd0;
   localparam logic [1:0] CS_DISC = 2'd1;
   localparam logic [1:0] CS_QUAR = 2'd2;
   localparam logic [1:0] CS_TOUT = 2'd3;

   typedef struct packed {
      logic [1:0]           cstate;
      logic [TIME_BITS-1:0] stamp;
      logic [7:0]           kind;
   } slot_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [ID_BITS-1:0]   id;
      logic [1:0]           cstate;
      logic [TIME_BITS-1:0] stamp;
      logic [7:0]           kind;
      logic                 last;
   } result_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      slot_type             wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } table_req_type;

endpackage

// ===== design/cti_table.sv =====
// slot table memory with one write port and one registered read port
module cti_table
   import cti_pkg::*;
(
   input  logic          clock,
   input  table_req_type tbl_req,
   output slot_type      rd_data_ff
);

   slot_type mem [SLOTS];

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr];
      end
   end

endmodule

// ===== design/cti_idle_cmp.sv =====
// idle time subtract and compare unit shared by every slot of a scan
module cti_idle_cmp
   import cti_pkg::*;
(
   input  logic [TIME_BITS-1:0] now_time,
   input  slot_type             slot,
   input  logic [TOUT_BITS-1:0] idle_timeout,
   output logic                 expired
);

   localparam int W = (TIME_BITS > TOUT_BITS) ? TIME_BITS : TOUT_BITS;

   logic [TIME_BITS-1:0] idle;

   assign idle    = now_time - slot.stamp;
   assign expired = (slot.cstate == CS_CONN) && (W'(idle) >= W'(idle_timeout));

endmodule

// ===== design/connection_table_idle_timeout.sv =====
// top level: connection table sequencer, timeout register and result register
//
// Each request transaction is handled on its own while req_ready is low. Open
// and failed lookups go straight to the result push; close, touch, quarantine
// and find do one table read, one read-modify-write and one result load; an
// expire scan walks the existing slots in id order through the single table
// read port and the one idle-time comparator, and an empty table skips the
// scan. A scan also waits whenever a second expired slot is found while the
// result register is still held by the consumer, and every transaction waits
// in its push state until the result register is free. Results leave through
// a result register, so a new request can be taken while a result waits. No
// clearing pass runs after reset.
module connection_table_idle_timeout
   import cti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [5:0]  req_conn_id,
   input  logic [7:0]  req_transport_code,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_result_id,
   output logic [1:0]  rsp_conn_state,
   output logic [31:0] rsp_last_seen,
   output logic [7:0]  rsp_slot_transport,
   output logic        rsp_last_of_run
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MODIFY = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FLUSH  = 3'd3;
   localparam logic [2:0] S_PUSH   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]  next_free_ff, next_free_in;
   logic [TOUT_BITS-1:0] timeout_ff, timeout_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           res_ff, res_in;
   result_type           rsp_ff, rsp_in;

   table_req_type        tbl_req;
   slot_type             rd_data;
   logic                 expired;
   logic                 rsp_free;
   logic                 accept;
   logic                 exists;
   logic [CNT_BITS-1:0]  idx_next;

   cti_table u_table (
      .clock      (clock),
      .tbl_req    (tbl_req),
      .rd_data_ff (rd_data)
   );

   cti_idle_cmp u_idle_cmp (
      .now_time     (now_ff),
      .slot         (rd_data),
      .idle_timeout (timeout_ff),
      .expired      (expired)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign exists    = CMP_BITS'(req_conn_id) < CMP_BITS'(next_free_ff);
   assign idx_next  = CNT_BITS'(idx_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      next_free_in = next_free_ff;
      timeout_in   = csr_wr_en ? TOUT_BITS'(csr_wr_data) : timeout_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tbl_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_operation;
               id_in      = ID_BITS'(req_conn_id);
               now_in     = TIME_BITS'(req_now_time);
               idx_in     = '0;
               found_in   = 1'b0;
               res_in     = '0;
               res_in.last = 1'b1;
               unique case (req_operation)
                  OP_OPEN: begin
                     state_in = S_PUSH;
                     if (req_transport_code == 8'd0) begin
                        res_in.status = ST_EMPTY;
                     end else if (next_free_ff >= CNT_BITS'(SLOTS)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        tbl_req.wr_en          = 1'b1;
                        tbl_req.wr_addr        = ADDR_BITS'(next_free_ff);
                        tbl_req.wr_data.cstate = CS_CONN;
                        tbl_req.wr_data.stamp  = TIME_BITS'(req_now_time);
                        tbl_req.wr_data.kind   = req_transport_code;
                        res_in.status = ST_OK;
                        res_in.id     = ID_BITS'(next_free_ff);
                        res_in.cstate = CS_CONN;
                        res_in.stamp  = TIME_BITS'(req_now_time);
                        res_in.kind   = req_transport_code;
                        next_free_in  = CNT_BITS'(next_free_ff + 1'b1);
                     end
                  end
                  OP_CLOSE, OP_TOUCH, OP_QUAR, OP_FIND: begin
                     if (!exists) begin
                        res_in.status = ST_NOID;
                        state_in      = S_PUSH;
                     end else begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = ADDR_BITS'(req_conn_id);
                        state_in        = S_MODIFY;
                     end
                  end
                  OP_EXPIRE: begin
                     if (next_free_ff == '0) begin
                        res_in.status = ST_NONE;
                        state_in      = S_PUSH;
                     end else begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = '0;
                        state_in        = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MODIFY: begin
            res_in.status   = ST_OK;
            res_in.id       = id_ff;
            res_in.cstate   = rd_data.cstate;
            res_in.stamp    = rd_data.stamp;
            res_in.kind     = rd_data.kind;
            res_in.last     = 1'b1;
            tbl_req.wr_addr = ADDR_BITS'(id_ff);
            tbl_req.wr_data = rd_data;
            unique case (op_ff)
               OP_CLOSE: begin
                  if (rd_data.cstate == CS_DISC) begin
                     res_in.status = ST_WRONG;
                  end else begin
                     tbl_req.wr_en          = 1'b1;
                     tbl_req.wr_data.cstate = CS_DISC;
                     res_in.cstate          = CS_DISC;
                  end
               end
               OP_TOUCH: begin
                  if (rd_data.cstate != CS_CONN) begin
                     res_in.status = ST_WRONG;
                  end else begin
                     tbl_req.wr_en         = 1'b1;
                     tbl_req.wr_data.stamp = now_ff;
                     res_in.stamp          = now_ff;
                  end
               end
               OP_QUAR: begin
                  if (rd_data.cstate != CS_CONN) begin
                     res_in.status = ST_WRONG;
                  end else begin
                     tbl_req.wr_en          = 1'b1;
                     tbl_req.wr_data.cstate = CS_QUAR;
                     res_in.cstate          = CS_QUAR;
                  end
               end
               default: begin
                  res_in.status = ST_OK;
               end
            endcase
            state_in = S_PUSH;
         end
         S_SCAN: begin
            // hold off while an earlier expired slot still needs the result register
            if (!(expired && found_ff && !rsp_free)) begin
               if (expired) begin
                  tbl_req.wr_en          = 1'b1;
                  tbl_req.wr_addr        = ADDR_BITS'(idx_ff);
                  tbl_req.wr_data        = rd_data;
                  tbl_req.wr_data.cstate = CS_TOUT;
                  if (found_ff) begin
                     rsp_in       = res_ff;
                     rsp_valid_in = 1'b1;
                  end
                  res_in.status = ST_OK;
                  res_in.id     = ID_BITS'(idx_ff);
                  res_in.cstate = CS_TOUT;
                  res_in.stamp  = rd_data.stamp;
                  res_in.kind   = rd_data.kind;
                  res_in.last   = 1'b0;
                  found_in      = 1'b1;
               end
               idx_in = idx_next;
               if (idx_next == next_free_ff) begin
                  state_in = S_FLUSH;
               end else begin
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = ADDR_BITS'(idx_next);
               end
            end
         end
         S_FLUSH: begin
            if (found_ff) begin
               res_in.last = 1'b1;
            end else begin
               res_in        = '0;
               res_in.status = ST_NONE;
               res_in.last   = 1'b1;
            end
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_free_ff <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         timeout_ff   <= timeout_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      id_ff  <= id_in;
      now_ff <= now_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_result_id      = 6'(rsp_ff.id);
   assign rsp_conn_state     = rsp_ff.cstate;
   assign rsp_last_seen      = 32'(rsp_ff.stamp);
   assign rsp_slot_transport = rsp_ff.kind;
   assign rsp_last_of_run    = rsp_ff.last;

endmodule
